// ----- rtl/icss_pkg.sv -----
// Shared types and constants for the icon size selector.
package icss_pkg;

    localparam int WORD_W = 32;
    localparam int COUNT_W = 64;
    localparam int PREF_W = 16;
    localparam logic [PREF_W-1:0] PREF_RESET = 16'd16;

    // A completed candidate icon, as handed from the parser to the best-icon keeper.
    typedef struct packed {
        logic               judge;
        logic [WORD_W-1:0]  width;
        logic [WORD_W-1:0]  height;
        logic [WORD_W-1:0]  offset;
        logic [COUNT_W-1:0] count;
    } icss_cand_t;

    // The best icon so far.
    typedef struct packed {
        logic               found;
        logic [WORD_W-1:0]  width;
        logic [WORD_W-1:0]  height;
        logic [COUNT_W-1:0] count;
        logic [WORD_W-1:0]  offset;
    } icss_best_t;

endpackage

// ----- rtl/icon_size_selector.sv -----
// Top level of the icon size selector: configuration, handshakes and result register.
//
// Usage: the words of a multi-icon property arrive on the s_ stream, one per
// transaction, with s_tlast on the final word. The preferred edge length is
// written on the cfg_ channel, which is always ready; write it while idle.
// The transaction carrying s_tlast produces one result on the m_ stream in
// the next cycle: m_tuser is the found flag and m_tdata holds width, height,
// pixel count and data offset, all zero when no icon was selected. Other
// words produce no result.
// Throughput is one word per cycle while s_tready is high; each word passes
// once through the parser and the best-icon compare into state registers,
// and a registered 32 x 32 multiplier forms the pixel count from the edges.
// The result register lets a new stream start while a result is pending;
// s_tready falls only while a result is held and m_tready is low.
// Reset clears the parse state and the pending result and sets the preferred
// size to 16.
module icon_size_selector
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data,    // preferred_size
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,     // word
    input  logic         s_tlast,     // last
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,     // icon_width, icon_height, pixel_count, data_offset
    output logic         m_tuser      // found
);
    import icss_pkg::*;

    logic [PREF_W-1:0] pref_reg;
    logic              step;
    logic              exact_stop;
    icss_cand_t        cand;
    icss_best_t        best_next;
    logic              m_valid_reg;
    logic [159:0]      m_data_reg;
    logic              m_user_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign step      = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pref_reg <= PREF_RESET;
        end
        else if (cfg_valid)
        begin
            pref_reg <= cfg_data;
        end
    end

    icss_parse u_parse
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .word       (s_tdata),
        .last       (s_tlast),
        .exact_stop (exact_stop),
        .cand       (cand)
    );

    icss_best u_best
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .last       (s_tlast),
        .pref       (pref_reg),
        .cand       (cand),
        .exact_stop (exact_stop),
        .best_next  (best_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (step && s_tlast)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && s_tlast)
        begin
            m_user_reg <= best_next.found;
            m_data_reg <= {best_next.offset, best_next.count, best_next.height,
                           best_next.width};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- rtl/icss_parse.sv -----
// Stream parser: header words, pixel counting and candidate hand-off.
module icss_parse
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [icss_pkg::WORD_W-1:0] word,
    input  logic                       last,
    input  logic                       exact_stop,
    output icss_pkg::icss_cand_t       cand
);
    import icss_pkg::*;

    localparam logic [1:0] PH_WIDTH  = 2'd0;
    localparam logic [1:0] PH_HEIGHT = 2'd1;
    localparam logic [1:0] PH_PIXELS = 2'd2;

    logic [1:0]         phase_reg, phase_next;
    logic               stopped_reg, stopped_next;
    logic               first_reg, first_next;
    logic [WORD_W-1:0]  index_reg, index_next;
    logic [WORD_W-1:0]  cand_w_reg, cand_w_next;
    logic [WORD_W-1:0]  cand_h_reg, cand_h_next;
    logic [WORD_W-1:0]  cand_off_reg, cand_off_next;
    logic [COUNT_W-1:0] pix_reg, pix_next;
    logic [COUNT_W-1:0] prod_reg;
    logic [COUNT_W-1:0] pix_inc;
    logic               done;
    logic               judge;

    assign pix_inc = pix_reg + COUNT_W'(1);

    // The product register lags the registered height word, so the first
    // pixel word decides completion from the edges directly.
    always_comb
    begin
        if (first_reg)
        begin
            done = (cand_w_reg == WORD_W'(1)) && (cand_h_reg == WORD_W'(1));
        end
        else
        begin
            done = (pix_inc == prod_reg);
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        stopped_next  = stopped_reg;
        first_next    = first_reg;
        cand_w_next   = cand_w_reg;
        cand_h_next   = cand_h_reg;
        cand_off_next = cand_off_reg;
        pix_next      = pix_reg;
        index_next    = index_reg + WORD_W'(1);
        judge         = 1'b0;
        if (!stopped_reg)
        begin
            case (phase_reg)
                PH_WIDTH:
                begin
                    if (word == '0)
                    begin
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        cand_w_next = word;
                        phase_next  = PH_HEIGHT;
                    end
                end
                PH_HEIGHT:
                begin
                    if (word == '0)
                    begin
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        cand_h_next   = word;
                        cand_off_next = index_reg + WORD_W'(1);
                        pix_next      = '0;
                        first_next    = 1'b1;
                        phase_next    = PH_PIXELS;
                    end
                end
                PH_PIXELS:
                begin
                    first_next = 1'b0;
                    if (done)
                    begin
                        phase_next = PH_WIDTH;
                        judge = step;
                        stopped_next = exact_stop;
                    end
                    else
                    begin
                        pix_next = pix_inc;
                    end
                end
                default:
                begin
                    phase_next = PH_WIDTH;
                end
            endcase
        end
    end

    assign cand = {judge, cand_w_reg, cand_h_reg, cand_off_reg,
                   first_reg ? COUNT_W'(1) : prod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_WIDTH;
            stopped_reg  <= 1'b0;
            first_reg    <= 1'b0;
            index_reg    <= '0;
            cand_w_reg   <= '0;
            cand_h_reg   <= '0;
            cand_off_reg <= '0;
            pix_reg      <= '0;
        end
        else if (step)
        begin
            if (last)
            begin
                phase_reg    <= PH_WIDTH;
                stopped_reg  <= 1'b0;
                first_reg    <= 1'b0;
                index_reg    <= '0;
                cand_w_reg   <= '0;
                cand_h_reg   <= '0;
                cand_off_reg <= '0;
                pix_reg      <= '0;
            end
            else
            begin
                phase_reg    <= phase_next;
                stopped_reg  <= stopped_next;
                first_reg    <= first_next;
                index_reg    <= index_next;
                cand_w_reg   <= cand_w_next;
                cand_h_reg   <= cand_h_next;
                cand_off_reg <= cand_off_next;
                pix_reg      <= pix_next;
            end
        end
    end

    // Registered 32 x 32 multiplier; its inputs hold steady through the pixel words.
    always_ff @(posedge clk)
    begin
        prod_reg <= COUNT_W'(cand_w_reg) * COUNT_W'(cand_h_reg);
    end

endmodule

// ----- rtl/icss_best.sv -----
// Best-icon keeper: judges each complete candidate against the current best.
module icss_best
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        last,
    input  logic [icss_pkg::PREF_W-1:0] pref,
    input  icss_pkg::icss_cand_t        cand,
    output logic                        exact_stop,
    output icss_pkg::icss_best_t        best_next
);
    import icss_pkg::*;

    icss_best_t        best_reg;
    logic [WORD_W-1:0] p;
    logic              big_enough;
    logic              smaller;
    logic              larger;
    logic              best_short;
    logic              take;

    assign p          = WORD_W'(pref);
    assign big_enough = (cand.width >= p) && (cand.height >= p);
    assign smaller    = (cand.width < best_reg.width) || (cand.height < best_reg.height);
    assign larger     = (cand.width > best_reg.width) || (cand.height > best_reg.height);
    assign best_short = (best_reg.width < p) || (best_reg.height < p);
    assign take       = !best_reg.found || (big_enough && (smaller || best_short))
                        || (!big_enough && best_short && larger);

    always_comb
    begin
        best_next = best_reg;
        if (cand.judge && take)
        begin
            best_next.found  = 1'b1;
            best_next.width  = cand.width;
            best_next.height = cand.height;
            best_next.count  = cand.count;
            best_next.offset = cand.offset;
        end
    end

    assign exact_stop = (best_next.width == p) && (best_next.height == p);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else if (step)
        begin
            if (last)
            begin
                best_reg <= '0;
            end
            else
            begin
                best_reg <= best_next;
            end
        end
    end

endmodule

// ----- rtl/icss_checker.sv -----
// Port-level checker for the icon size selector, bound to the top level.
module icss_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         s_tlast,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [159:0] m_tdata,
    input logic         m_tuser
);

    // A held result keeps its contents until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A final-word transaction always yields a result in the next cycle.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no result after final word");

    // Without a selected icon every field reads zero.
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("fields not zero when nothing found");

    // A selected icon has non-zero edges and pixel count.
    a_found_sane: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[31:0] != '0 && m_tdata[63:32] != '0
                                && m_tdata[127:64] != '0)
        else $error("selected icon with zero size");

    // A stalled result blocks the input side.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while result stalled");

endmodule

bind icon_size_selector icss_checker u_icss_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
